// File: rtl/core/dst_pkg.sv
// Shared types and constants for the devicetree structure tokenizer.
// Used by dst_front, dst_queue, dst_back and the top level; depends on nothing.
package dst_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned KIND_W     = 4;
    localparam int unsigned LEFT_W     = 31;
    localparam int unsigned WORD_BYTES = 4;
    localparam logic [7:0]  BYTE_MASK  = 8'hFF;

    // Structure block token values
    localparam logic [WORD_W-1:0] TOKEN_BEGIN_NODE = 32'd1;
    localparam logic [WORD_W-1:0] TOKEN_END_NODE   = 32'd2;
    localparam logic [WORD_W-1:0] TOKEN_PROP       = 32'd3;
    localparam logic [WORD_W-1:0] TOKEN_NOP        = 32'd4;
    localparam logic [WORD_W-1:0] TOKEN_END        = 32'd9;

    // Result classification codes
    localparam logic [KIND_W-1:0] KIND_BEGIN   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_NAME    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_ENDNODE = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PROP    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_LEN     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_NAMEOFF = 4'd5;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NOP     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_END     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 4'd10;

    // Pre-decoded token class of a word
    typedef enum logic [2:0] {
        TOK_BEGIN_NODE = 3'd0,
        TOK_END_NODE   = 3'd1,
        TOK_PROP       = 3'd2,
        TOK_NOP        = 3'd3,
        TOK_END        = 3'd4,
        TOK_BAD        = 3'd5
    } tok_t;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_TOKEN   = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_NAMEOFF = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    // Classified word handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              restart;
        tok_t              tok;
        logic              has_zero;
        logic [LEFT_W-1:0] ceil_words;
    } dst_item_t;

endpackage

// File: rtl/core/dst_front.sv
// Front end: accepts words, decodes token class, zero byte and payload word count.
// Depends on dst_pkg.
module dst_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        in_word,
    input  logic               in_restart,
    output logic               out_valid,
    input  logic               out_ready,
    output dst_pkg::dst_item_t out_item
);
    import dst_pkg::*;

    logic      valid_reg;
    dst_item_t item_reg;
    dst_item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next.word    = in_word;
        item_next.restart = in_restart;
        item_next.has_zero = 1'b0;
        for (int i = 0; i < WORD_BYTES; i++) begin
            if ((in_word[8*i +: 8] & BYTE_MASK) == 8'd0) begin
                item_next.has_zero = 1'b1;
            end
        end
        // ceil(len / 4)
        item_next.ceil_words = {1'b0, in_word[WORD_W-1:2]} + LEFT_W'(|in_word[1:0]);
        case (in_word)
            TOKEN_BEGIN_NODE: item_next.tok = TOK_BEGIN_NODE;
            TOKEN_END_NODE:   item_next.tok = TOK_END_NODE;
            TOKEN_PROP:       item_next.tok = TOK_PROP;
            TOKEN_NOP:        item_next.tok = TOK_NOP;
            TOKEN_END:        item_next.tok = TOK_END;
            default:          item_next.tok = TOK_BAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/core/dst_queue.sv
// Two-entry queue of classified words between front and back.
// Depends on dst_pkg.
module dst_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  dst_pkg::dst_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output dst_pkg::dst_item_t pop_item
);
    import dst_pkg::*;

    localparam int unsigned DEPTH = 2;

    dst_item_t   mem [DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/dst_back.sv
// Back end: parser phase, payload counter and stop flag; registers the result word.
// Depends on dst_pkg.
module dst_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  dst_pkg::dst_item_t in_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_kind,
    output logic               m_name_done,
    output logic [31:0]        m_length_value,
    output logic [31:0]        m_name_offset
);
    import dst_pkg::*;

    phase_t              phase_reg, phase_next, cur_phase;
    logic [LEFT_W-1:0]   left_reg, left_next, cur_left, left_dec;
    logic                stopped_reg, stopped_next, cur_stopped;
    logic                m_valid_reg;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                done_reg, done_next;
    logic [WORD_W-1:0]   lenv_reg, lenv_next;
    logic [WORD_W-1:0]   noff_reg, noff_next;
    logic                take;

    assign in_ready       = !m_valid_reg || m_ready;
    assign take           = in_valid && in_ready;
    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_name_done    = done_reg;
    assign m_length_value = lenv_reg;
    assign m_name_offset  = noff_reg;

    always_comb begin
        // Restart drops any node name or property in progress
        cur_phase   = in_item.restart ? PH_TOKEN : phase_reg;
        cur_left    = in_item.restart ? '0 : left_reg;
        cur_stopped = in_item.restart ? 1'b0 : stopped_reg;
        left_dec    = (cur_left != '0) ? cur_left - LEFT_W'(1) : cur_left;

        phase_next   = cur_phase;
        left_next    = cur_left;
        stopped_next = cur_stopped;
        kind_next    = KIND_IGNORED;
        done_next    = 1'b0;
        lenv_next    = '0;
        noff_next    = '0;

        if (!cur_stopped) begin
            case (cur_phase)
                PH_NAME: begin
                    kind_next = KIND_NAME;
                    if (in_item.has_zero) begin
                        done_next  = 1'b1;
                        phase_next = PH_TOKEN;
                    end
                end
                PH_LEN: begin
                    kind_next  = KIND_LEN;
                    lenv_next  = in_item.word;
                    left_next  = in_item.ceil_words;
                    phase_next = PH_NAMEOFF;
                end
                PH_NAMEOFF: begin
                    kind_next  = KIND_NAMEOFF;
                    noff_next  = in_item.word;
                    phase_next = (cur_left != '0) ? PH_PAYLOAD : PH_TOKEN;
                end
                PH_PAYLOAD: begin
                    kind_next = KIND_PAYLOAD;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        phase_next = PH_TOKEN;
                    end
                end
                default: begin
                    phase_next = PH_TOKEN;
                    case (in_item.tok)
                        TOK_BEGIN_NODE: begin
                            kind_next  = KIND_BEGIN;
                            phase_next = PH_NAME;
                        end
                        TOK_END_NODE: kind_next = KIND_ENDNODE;
                        TOK_PROP: begin
                            kind_next  = KIND_PROP;
                            phase_next = PH_LEN;
                        end
                        TOK_NOP: kind_next = KIND_NOP;
                        TOK_END: begin
                            kind_next    = KIND_END;
                            stopped_next = 1'b1;
                        end
                        default: begin
                            kind_next    = KIND_ERROR;
                            stopped_next = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TOKEN;
            left_reg    <= '0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg   <= phase_next;
                left_reg    <= left_next;
                stopped_reg <= stopped_next;
            end
            if (in_ready) begin
                m_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg <= kind_next;
            done_reg <= done_next;
            lenv_reg <= lenv_next;
            noff_reg <= noff_next;
        end
    end

endmodule

// File: rtl/core/devicetree_struct_tokenizer.sv
// Top level of the devicetree structure block tokenizer.
// Instantiates dst_front, dst_queue and dst_back; depends on dst_pkg.
//
// The tokenizer takes one 32-bit structure block word per cycle (already in
// big-endian value order) and gives exactly one classification word for each
// input word, in order. Sustained rate is one word per cycle while the result
// side is not stalled; each word passes through the front decode register,
// then the queue and then the result register. The front decodes the token
// class, a zero-byte flag and ceil(len/4) for every word; the back holds the
// parser phase, payload counter and stop flag and updates them once per
// word, which sets the one-word-per-cycle figure. A two-entry queue lets the
// front keep taking words while the result side stalls, until the queue is
// full. After an end token or an unknown token every word is marked ignored
// until a word arrives with s_restart high, which is then taken as a token.
module devicetree_struct_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_word,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic        m_name_done,
    output logic [31:0] m_length_value,
    output logic [31:0] m_name_offset
);
    import dst_pkg::*;

    // Front to queue
    logic      fq_valid;
    logic      fq_ready;
    dst_item_t fq_item;

    // Queue to back
    logic      qb_valid;
    logic      qb_ready;
    dst_item_t qb_item;

    // Decode each word as it arrives
    dst_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_word    (s_word),
        .in_restart (s_restart),
        .out_valid  (fq_valid),
        .out_ready  (fq_ready),
        .out_item   (fq_item)
    );

    // Hold decoded words while the back end stalls
    dst_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // Advance the parser state and register the result word
    dst_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (qb_valid),
        .in_ready       (qb_ready),
        .in_item        (qb_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_name_done    (m_name_done),
        .m_length_value (m_length_value),
        .m_name_offset  (m_name_offset)
    );

endmodule
